@@ sv/etbb_pkg.sv @@
// Shared constants and transaction types for the endian typed byte buffer access unit.
`default_nettype none

package etbb_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int LANES        = 8;
  localparam int LANE_W       = $clog2(LANES);
  localparam int BUF_AW       = $clog2(BUFFER_BYTES);
  localparam int ROWS         = BUFFER_BYTES / LANES;
  localparam int ROW_W        = BUF_AW - LANE_W;

  localparam int REG_W     = 13;
  localparam int OFF_W     = 12;
  localparam int DATA_W    = 64;
  localparam int SIZE_W    = 4;
  localparam int END_W     = (BUF_AW + 1 > REG_W + 1) ? BUF_AW + 1 : REG_W + 1;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_OFFSET = 1'b0,
    REG_VIEW_LENGTH = 1'b1
  } cfg_reg_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] SIZE_1B = 2'd0;
  localparam logic [1:0] SIZE_2B = 2'd1;
  localparam logic [1:0] SIZE_4B = 2'd2;
  localparam logic [1:0] SIZE_8B = 2'd3;

  typedef struct packed {
    logic              op;
    logic [1:0]        size_code;
    logic              sign_extend;
    logic              little_endian;
    logic [OFF_W-1:0]  byte_offset;
    logic [DATA_W-1:0] write_data;
  } access_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              range_error;
  } access_result_t;

endpackage

`default_nettype wire

@@ sv/endian_typed_byte_buffer_access_unit.sv @@
// Top level: byte-banked buffer with endian-selectable unaligned loads and stores.
//
// Usage:
//   Command channel: an access transaction is taken at a rising edge where start is
//   high and busy is low. item carries op, size, sign-extension, byte order, the
//   offset inside the view and the store data.
//   Result channel: done pulses for one cycle with result valid; the receiver
//   cannot stall, so it must take the transaction in that cycle.
//   Config port: cfg_we writes cfg_wdata into view_offset (index 0) or
//   view_length (index 1) at once; write only while the unit is idle.
// Sequence: a store or an out-of-range access is finished in S_ACCESS, which
//   registers done; a load reads a row of the eight byte banks in S_ACCESS, then
//   lane assembly and extension in S_RESP. busy is low again in the cycle done is
//   high, so a new transaction can be taken then, but not before the last is done.
// Storage: eight byte-wide banks of BUFFER_BYTES/8 rows; an unaligned access
//   touches each bank at most once, so one bank access per cycle covers it.
// Reset: config and control registers go to zero and a clearing pass zeroes
//   one row of all banks per cycle over BUFFER_BYTES/8 = 512 rows; busy stays high.
`default_nettype none

module endian_typed_byte_buffer_access_unit
  import etbb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire access_item_t         item,
  output logic                      done,
  output access_result_t            result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_RESP
  } state_t;

  state_t            state;
  logic [ROW_W-1:0]  clr_row;
  access_item_t      item_q;
  logic [REG_W-1:0]  view_offset;
  logic [REG_W-1:0]  view_length;

  logic [7:0]        bank_mem [LANES][ROWS];
  logic [7:0]        bank_q   [LANES];

  logic              mem_we    [LANES];
  logic [ROW_W-1:0]  mem_row   [LANES];
  logic [7:0]        mem_wdata [LANES];

  logic [SIZE_W-1:0] size_bytes;
  logic [LANE_W-1:0] size_m1;
  logic [END_W-1:0]  base_sum;
  logic [END_W-1:0]  buf_end;
  logic [REG_W-1:0]  view_end;
  logic              fits;
  logic [LANE_W-1:0] base_lo;
  logic [ROW_W-1:0]  base_row;
  logic [DATA_W-1:0] raw_data;
  logic [DATA_W-1:0] ext_data;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      view_offset <= '0;
      view_length <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VIEW_OFFSET: view_offset <= cfg_wdata;
        REG_VIEW_LENGTH: view_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    size_bytes = SIZE_W'(1) << item_q.size_code;
    size_m1    = LANE_W'(size_bytes - SIZE_W'(1));
    view_end   = REG_W'(item_q.byte_offset) + REG_W'(size_bytes);
    base_sum   = END_W'(view_offset) + END_W'(item_q.byte_offset);
    buf_end    = base_sum + END_W'(size_bytes);
    fits       = (view_end <= view_length) && (buf_end <= END_W'(BUFFER_BYTES));
    base_lo    = base_sum[LANE_W-1:0];
    base_row   = base_sum[BUF_AW-1:LANE_W];
  end

  always_comb begin
    logic [LANE_W-1:0] idx;
    logic [LANE_W-1:0] lane;
    for (int b = 0; b < LANES; b++) begin
      idx  = LANE_W'(b) - base_lo;
      lane = item_q.little_endian ? idx : (size_m1 - idx);
      if (state == S_CLEAR) begin
        mem_we[b]    = 1'b1;
        mem_row[b]   = clr_row;
        mem_wdata[b] = 8'h00;
      end else begin
        mem_we[b]    = (state == S_ACCESS) && fits && (item_q.op == OP_WRITE) &&
                       (SIZE_W'(idx) < size_bytes);
        mem_row[b]   = base_row + ROW_W'(LANE_W'(b) < base_lo);
        mem_wdata[b] = item_q.write_data[{lane, 3'b000} +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < LANES; b++) begin
      if (mem_we[b]) begin
        bank_mem[b][mem_row[b]] <= mem_wdata[b];
      end
      bank_q[b] <= bank_mem[b][mem_row[b]];
    end
  end

  always_comb begin
    logic [LANE_W-1:0] idx;
    logic [LANE_W-1:0] bsel;
    raw_data = '0;
    for (int l = 0; l < LANES; l++) begin
      idx  = item_q.little_endian ? LANE_W'(l) : (size_m1 - LANE_W'(l));
      bsel = base_lo + idx;
      if (SIZE_W'(l) < size_bytes) begin
        raw_data[8*l +: 8] = bank_q[bsel];
      end
    end
    ext_data = raw_data;
    if (item_q.sign_extend) begin
      case (item_q.size_code)
        SIZE_1B: ext_data = {{56{raw_data[7]}}, raw_data[7:0]};
        SIZE_2B: ext_data = {{48{raw_data[15]}}, raw_data[15:0]};
        SIZE_4B: ext_data = {{32{raw_data[31]}}, raw_data[31:0]};
        default: ext_data = raw_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + ROW_W'(1);
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item_q <= item;
            state  <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          if (!fits) begin
            result.read_data   <= '0;
            result.range_error <= 1'b1;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else if (item_q.op == OP_WRITE) begin
            result.read_data   <= '0;
            result.range_error <= 1'b0;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          result.read_data   <= ext_data;
          result.range_error <= 1'b0;
          done               <= 1'b1;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("done outside idle");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.range_error) |-> (result.read_data == '0))
    else $error("error transaction carries data");

  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_ACCESS))
    else $error("transaction not taken");

  a_resp_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> ($past(state) == S_ACCESS))
    else $error("response without bank read");

  a_clear_after_rst: assert property (@(posedge clk)
    $fell(rst) |-> (state == S_CLEAR && clr_row == '0))
    else $error("clearing pass not started");
`endif

endmodule

`default_nettype wire
